[rtl/orthogonal_series_evaluator_defines.svh]
// Assertion macros for the orthogonal series evaluator.
`ifndef ORTHOGONAL_SERIES_EVALUATOR_DEFINES_SVH
`define ORTHOGONAL_SERIES_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ose_pkg.sv]
// Shared types, constants and saturating add/sub for the orthogonal series evaluator.
package ose_pkg;

  localparam int DATA_W          = 32;
  localparam int X_W             = 26;
  localparam int IDX_W           = 5;
  localparam int DEG_W           = 5;
  localparam int MAX_DEGREE_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 24;
  localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(2);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } addsub_t;

  typedef struct packed {
    logic                     done;
    logic                     ovf;
    logic signed [DATA_W-1:0] u;
  } ose_res_t;

  function automatic addsub_t sat_addsub(input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b,
                                         input logic                     sub);
    logic [DATA_W:0] sum;
    addsub_t         r;
    if (sub) begin
      sum = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      r.sat = 1'b1;
      r.val = sum[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = sum[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/ose_mul.sv]
// Shared two-stage fixed-point multiplier with floor shift and saturation.
module ose_mul
  import ose_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     issue,
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output logic signed [DATA_W-1:0] res,
  output logic                     res_sat
);

  localparam int PROD_W = 2 * DATA_W;

  logic                     issue_d_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] shifted;
  logic [PROD_W-DATA_W:0]   hi;
  logic                     sat;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] res_r;
  logic                     res_sat_r;

  always_comb begin
    shifted = prod_r >>> FRAC_BITS;
    hi      = shifted[PROD_W-1:DATA_W-1];
    sat     = !((&hi) || (~|hi));
    if (sat) begin
      val = shifted[PROD_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      val = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r <= 1'b0;
    end else begin
      issue_d_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= op_a * op_b;
    end
    if (issue_d_r) begin
      res_r     <= val;
      res_sat_r <= sat;
    end
  end

  assign res     = res_r;
  assign res_sat = res_sat_r;

endmodule

[rtl/ose_tables.sv]
// Alpha, beta and coefficient memories with registered read.
module ose_tables
  import ose_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [IDX_W-1:0]                      wr_idx,
  input  logic signed [DATA_W-1:0]              wr_alpha,
  input  logic signed [DATA_W-1:0]              wr_beta,
  input  logic signed [DATA_W-1:0]              wr_coef,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]       rd_j,
  output logic signed [DATA_W-1:0]              alpha_rd,
  output logic signed [DATA_W-1:0]              beta_rd,
  output logic signed [DATA_W-1:0]              coef_rd
);

  localparam int AW  = $clog2(MAX_DEGREE + 1);
  localparam int ABW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic signed [DATA_W-1:0] alpha_mem [MAX_DEGREE];
  logic signed [DATA_W-1:0] beta_mem  [MAX_DEGREE];
  logic signed [DATA_W-1:0] coef_mem  [MAX_DEGREE+1];
  logic signed [DATA_W-1:0] alpha_rd_r;
  logic signed [DATA_W-1:0] beta_rd_r;
  logic signed [DATA_W-1:0] coef_rd_r;
  logic [AW-1:0]            wa;
  logic [AW-1:0]            ra;
  logic [ABW-1:0]           wa_ab;
  logic [ABW-1:0]           ra_ab;

  assign wa    = AW'(wr_idx);
  assign ra    = rd_j - AW'(1);
  assign wa_ab = wa[ABW-1:0];
  assign ra_ab = ra[ABW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_idx) < MAX_DEGREE)) begin
      alpha_mem[wa_ab] <= wr_alpha;
      beta_mem[wa_ab]  <= wr_beta;
    end
    if (wr_en && (int'(wr_idx) <= MAX_DEGREE)) begin
      coef_mem[wa] <= wr_coef;
    end
  end

  always_ff @(posedge clk) begin
    coef_rd_r <= coef_mem[rd_j];
    if (rd_j != '0) begin
      alpha_rd_r <= alpha_mem[ra_ab];
      beta_rd_r  <= beta_mem[ra_ab];
    end
  end

  assign alpha_rd = alpha_rd_r;
  assign beta_rd  = beta_rd_r;
  assign coef_rd  = coef_rd_r;

endmodule

[rtl/ose_seq.sv]
// Sequencer for the recurrence and series sum around the shared multiplier.
module ose_seq
  import ose_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [X_W-1:0]             x,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]   n,
  input  logic                              out_free,
  input  logic signed [DATA_W-1:0]          alpha_rd,
  input  logic signed [DATA_W-1:0]          beta_rd,
  input  logic signed [DATA_W-1:0]          coef_rd,
  output logic [$clog2(MAX_DEGREE+1)-1:0]   rd_j,
  output logic                              mul_issue,
  output logic signed [DATA_W-1:0]          mul_a,
  output logic signed [DATA_W-1:0]          mul_b,
  input  logic signed [DATA_W-1:0]          mul_res,
  input  logic                              mul_sat,
  output logic                              busy,
  output ose_res_t                          res
);

  localparam int AW = $clog2(MAX_DEGREE + 1);
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_M0   = 18'h00002,
    ST_M0W  = 18'h00004,
    ST_S0   = 18'h00008,
    ST_T    = 18'h00010,
    ST_MA   = 18'h00020,
    ST_MB   = 18'h00040,
    ST_WA   = 18'h00080,
    ST_Q    = 18'h00100,
    ST_MC   = 18'h00200,
    ST_MCW  = 18'h00400,
    ST_ACC  = 18'h00800,
    ST_XX   = 18'h01000,
    ST_XW   = 18'h02000,
    ST_W    = 18'h04000,
    ST_MU   = 18'h08000,
    ST_MUW  = 18'h10000,
    ST_DONE = 18'h20000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            j_r, j_nxt;
  logic [AW-1:0]            n_r, n_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] q1_r, q1_nxt;
  logic signed [DATA_W-1:0] q2_r, q2_nxt;
  logic signed [DATA_W-1:0] tmp_r, tmp_nxt;
  logic signed [DATA_W-1:0] s_r, s_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [DATA_W-1:0] add_a, add_b;
  logic                     add_sub;
  addsub_t                  add_res;

  always_comb begin
    add_a   = x_r;
    add_b   = alpha_rd;
    add_sub = 1'b1;
    unique case (state_r)
      ST_Q: begin
        add_a = tmp_r;
        add_b = mul_res;
      end
      ST_ACC: begin
        add_a   = s_r;
        add_b   = mul_res;
        add_sub = 1'b0;
      end
      ST_W: begin
        add_a = ONE;
        add_b = mul_res;
      end
      default: begin
        add_a = x_r;
        add_b = alpha_rd;
      end
    endcase
    add_res = sat_addsub(add_a, add_b, add_sub);
  end

  always_comb begin
    mul_issue = 1'b0;
    mul_a     = tmp_r;
    mul_b     = q1_r;
    unique case (state_r)
      ST_M0: begin
        mul_issue = 1'b1;
        mul_a     = coef_rd;
        mul_b     = ONE;
      end
      ST_MA: begin
        mul_issue = 1'b1;
      end
      ST_MB: begin
        mul_issue = 1'b1;
        mul_a     = beta_rd;
        mul_b     = q2_r;
      end
      ST_MC: begin
        mul_issue = 1'b1;
        mul_a     = coef_rd;
      end
      ST_XX: begin
        mul_issue = 1'b1;
        mul_a     = x_r;
        mul_b     = x_r;
      end
      ST_MU: begin
        mul_issue = 1'b1;
        mul_b     = s_r;
      end
      default: begin
        mul_issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    x_nxt     = x_r;
    q1_nxt    = q1_r;
    q2_nxt    = q2_r;
    tmp_nxt   = tmp_r;
    s_nxt     = s_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        j_nxt = '0;
        if (start) begin
          n_nxt     = n;
          x_nxt     = DATA_W'(x);
          q1_nxt    = ONE;
          q2_nxt    = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_M0;
        end
      end
      ST_M0:  state_nxt = ST_M0W;
      ST_M0W: state_nxt = ST_S0;
      ST_S0: begin
        s_nxt   = mul_res;
        ovf_nxt = ovf_r | mul_sat;
        if (n_r == '0) begin
          state_nxt = ST_XX;
        end else begin
          j_nxt     = AW'(1);
          state_nxt = ST_T;
        end
      end
      ST_T: begin
        tmp_nxt   = add_res.val;
        ovf_nxt   = ovf_r | add_res.sat;
        state_nxt = ST_MA;
      end
      ST_MA: state_nxt = ST_MB;
      ST_MB: state_nxt = ST_WA;
      ST_WA: begin
        tmp_nxt   = mul_res;
        ovf_nxt   = ovf_r | mul_sat;
        state_nxt = ST_Q;
      end
      ST_Q: begin
        q1_nxt    = add_res.val;
        q2_nxt    = q1_r;
        ovf_nxt   = ovf_r | mul_sat | add_res.sat;
        state_nxt = ST_MC;
      end
      ST_MC:  state_nxt = ST_MCW;
      ST_MCW: state_nxt = ST_ACC;
      ST_ACC: begin
        s_nxt   = add_res.val;
        ovf_nxt = ovf_r | mul_sat | add_res.sat;
        if (j_r == n_r) begin
          state_nxt = ST_XX;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = ST_T;
        end
      end
      ST_XX: state_nxt = ST_XW;
      ST_XW: state_nxt = ST_W;
      ST_W: begin
        tmp_nxt   = add_res.val;
        ovf_nxt   = ovf_r | mul_sat | add_res.sat;
        state_nxt = ST_MU;
      end
      ST_MU:  state_nxt = ST_MUW;
      ST_MUW: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      n_r     <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    q1_r  <= q1_nxt;
    q2_r  <= q2_nxt;
    tmp_r <= tmp_nxt;
    s_r   <= s_nxt;
  end

  assign rd_j     = j_nxt;
  assign busy     = (state_r != ST_IDLE);
  assign res.done = (state_r == ST_DONE);
  assign res.ovf  = ovf_r | mul_sat;
  assign res.u    = mul_res;

endmodule

[rtl/orthogonal_series_evaluator.sv]
// Top level of the orthogonal series evaluator: handshakes, degree register, result register.
//
// Computes u(x) = (1 - x^2) * sum_{j=0..n} coef[j] * q_j(x) in signed Q8.24 (by default),
// with q_j from a three-term recurrence and n = min(degree, MAX_DEGREE). A load item writes
// one alpha/beta/coef entry and leaves in_stall low. An evaluate item holds in_stall high
// after its transfer while the sequencer runs, and out_valid rises in the cycle in which
// in_stall falls, unless an earlier result still waits on out_stall; the sequencer shares a
// single two-stage 32x32 multiplier that each recurrence step uses three times. The next item
// can be taken while a result waits on out_stall.
`include "orthogonal_series_evaluator_defines.svh"
module orthogonal_series_evaluator
  import ose_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_alpha_value,
  input  logic signed [DATA_W-1:0] in_beta_value,
  input  logic signed [DATA_W-1:0] in_coef_value,
  input  logic signed [X_W-1:0]    in_x_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_u_value,
  output logic                     out_overflow,
  input  logic                     cfg_wr_en,
  input  logic [DEG_W-1:0]         cfg_wr_data
);

  localparam int AW = $clog2(MAX_DEGREE + 1);

  logic [DEG_W-1:0]         degree_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_u_r;
  logic                     out_ovf_r;
  logic                     in_xfer;
  logic                     busy;
  logic                     out_free;
  logic [AW-1:0]            n_clip;
  logic [AW-1:0]            rd_j;
  logic signed [DATA_W-1:0] alpha_rd, beta_rd, coef_rd;
  logic                     mul_issue;
  logic signed [DATA_W-1:0] mul_a, mul_b, mul_res;
  logic                     mul_sat;
  ose_res_t                 res;

  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign n_clip   = (int'(degree_r) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(degree_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RESET;
    end else if (cfg_wr_en) begin
      degree_r <= cfg_wr_data;
    end
  end

  ose_tables #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_tables (
    .clk      (clk),
    .wr_en    (in_xfer && (in_opcode == OP_LOAD)),
    .wr_idx   (in_entry_index),
    .wr_alpha (in_alpha_value),
    .wr_beta  (in_beta_value),
    .wr_coef  (in_coef_value),
    .rd_j     (rd_j),
    .alpha_rd (alpha_rd),
    .beta_rd  (beta_rd),
    .coef_rd  (coef_rd)
  );

  ose_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (mul_issue),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .res     (mul_res),
    .res_sat (mul_sat)
  );

  ose_seq #(
    .MAX_DEGREE(MAX_DEGREE),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer && (in_opcode == OP_EVAL)),
    .x         (in_x_value),
    .n         (n_clip),
    .out_free  (out_free),
    .alpha_rd  (alpha_rd),
    .beta_rd   (beta_rd),
    .coef_rd   (coef_rd),
    .rd_j      (rd_j),
    .mul_issue (mul_issue),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_res   (mul_res),
    .mul_sat   (mul_sat),
    .busy      (busy),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done && out_free) begin
      out_u_r   <= res.u;
      out_ovf_r <= res.ovf;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_u_value  = out_u_r;
  assign out_overflow = out_ovf_r;

  `OSE_ASSERT_NEXT(a_eval_goes_busy, clk, rst_n, in_xfer && (in_opcode == OP_EVAL), in_stall, "evaluate transfer did not start the sequencer")
  `OSE_ASSERT_NEXT(a_load_stays_ready, clk, rst_n, in_xfer && (in_opcode == OP_LOAD), !in_stall, "load transfer left the block busy")
  `OSE_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared without an evaluation in flight")

endmodule
